>>> hw/rtl/bfrd_pkg.sv
package bfrd_pkg;

    localparam int SLOTS_DEF = 16;

    localparam int SLOT_FIELD_W = 4;
    localparam int BOUND_W      = 32;

    localparam int S_TDATA_W = 104;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 8;

    localparam logic OP_SET   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic                    op;
        logic [SLOT_FIELD_W-1:0] slot;
        logic [BOUND_W-1:0]      range_low;
        logic [BOUND_W-1:0]      range_high;
        logic [BOUND_W-1:0]      demand_size;
        logic                    claim;
    } bfrd_cmd_t;

    typedef struct packed {
        logic                    found;
        logic [SLOT_FIELD_W-1:0] chosen_slot;
    } bfrd_result_t;

endpackage

>>> hw/rtl/best_fit_range_dispatcher.sv
// Best-fit range dispatcher.
// Input channel s_*: one transfer is one item. s_tuser carries op (set or query); s_tdata
// carries the slot index, the inclusive range, the request size and the claim flag.
// Output channel m_*: exactly one result transfer per input item, with found and the
// chosen slot in m_tdata.
// A set writes the slot's bounds into the table memory and marks it available; its result
// is registered in the sequencer and then in the output register before it reaches m_tvalid.
// A query sweeps the table one slot per cycle through a single read port and one shared
// compare unit; its result then passes through the sequencer's result register and the
// output register to m_tvalid. The sweep length is set by that single memory read port.
// One item is processed at a time: s_tready is high only while the sequencer is idle.
// A finished result waits in the output register, so the next item is accepted while the
// receiver stalls; a further result then holds in the sequencer until m_tready.
// Reset clears every available mark and empties the output register. The bounds memory is
// not cleared; a slot's bounds are used only once a set has marked the slot available.
module best_fit_range_dispatcher #(
    parameter int SLOTS = bfrd_pkg::SLOTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata from bit 0: slot[3:0], range_low[31:0], range_high[31:0], demand_size[31:0],
    // claim, zero padding.
    input  logic [bfrd_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: op (0 = set, 1 = query).
    input  logic [bfrd_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata from bit 0: found, chosen_slot[3:0], zero padding.
    output logic [bfrd_pkg::M_TDATA_W-1:0] m_tdata
);
    import bfrd_pkg::*;

    bfrd_cmd_t    cmd;
    bfrd_result_t res;
    logic         ctrl_idle;
    logic         res_valid;
    logic         out_load;
    logic         m_tvalid_reg, m_tvalid_next;
    bfrd_result_t out_reg, out_next;

    assign cmd.op          = s_tuser[0];
    assign cmd.slot        = s_tdata[3:0];
    assign cmd.range_low   = s_tdata[35:4];
    assign cmd.range_high  = s_tdata[67:36];
    assign cmd.demand_size = s_tdata[99:68];
    assign cmd.claim       = s_tdata[100];

    assign s_tready = ctrl_idle;
    assign out_load = res_valid && (!m_tvalid_reg || m_tready);

    bfrd_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (s_tvalid && ctrl_idle),
        .cmd       (cmd),
        .idle      (ctrl_idle),
        .res_valid (res_valid),
        .res_ready (out_load),
        .res       (res)
    );

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        out_next      = out_reg;
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
            out_next      = res;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, out_reg.chosen_slot, out_reg.found};

endmodule

>>> hw/rtl/bfrd_bounds.sv
module bfrd_bounds #(
    parameter int SLOTS  = bfrd_pkg::SLOTS_DEF,
    parameter int SLOT_W = 4
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [SLOT_W-1:0]           wr_addr,
    input  logic [bfrd_pkg::BOUND_W-1:0] wr_lower,
    input  logic [bfrd_pkg::BOUND_W-1:0] wr_upper,
    input  logic                        rd_en,
    input  logic [SLOT_W-1:0]           rd_addr,
    output logic [bfrd_pkg::BOUND_W-1:0] rd_lower,
    output logic [bfrd_pkg::BOUND_W-1:0] rd_upper
);
    import bfrd_pkg::*;

    // Each entry holds the lower bound in the high half and the upper bound in the low half.
    logic [2*BOUND_W-1:0] mem [SLOTS];
    logic [2*BOUND_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_lower, wr_upper};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_lower = rd_data_reg[2*BOUND_W-1:BOUND_W];
    assign rd_upper = rd_data_reg[BOUND_W-1:0];

endmodule

>>> hw/rtl/bfrd_ctrl.sv
module bfrd_ctrl #(
    parameter int SLOTS = bfrd_pkg::SLOTS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  bfrd_pkg::bfrd_cmd_t    cmd,
    output logic                   idle,
    output logic                   res_valid,
    input  logic                   res_ready,
    output bfrd_pkg::bfrd_result_t res
);
    import bfrd_pkg::*;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]         state_reg, state_next;
    bfrd_cmd_t          cmd_reg, cmd_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic [SLOT_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic               hit_reg, hit_next;
    logic [SLOT_W-1:0]  best_reg, best_next;
    logic [BOUND_W-1:0] best_upper_reg, best_upper_next;
    logic [SLOTS-1:0]   marks_reg, marks_next;
    bfrd_result_t       res_reg, res_next;

    logic               set_in_range;
    logic               wr_en;
    logic [SLOT_W-1:0]  wr_addr;
    logic               issue;
    logic [BOUND_W-1:0] rd_lower;
    logic [BOUND_W-1:0] rd_upper;
    logic               covers;

    assign set_in_range = 32'(cmd.slot) < 32'(SLOTS);
    assign wr_addr      = SLOT_W'(cmd.slot);
    assign wr_en        = (state_reg == ST_IDLE) && start && (cmd.op == OP_SET) && set_in_range;
    assign issue        = (state_reg == ST_SCAN) && (idx_reg < CNT_W'(SLOTS));

    bfrd_bounds #(
        .SLOTS  (SLOTS),
        .SLOT_W (SLOT_W)
    ) u_bounds (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_lower (cmd.range_low),
        .wr_upper (cmd.range_high),
        .rd_en    (issue),
        .rd_addr  (idx_reg[SLOT_W-1:0]),
        .rd_lower (rd_lower),
        .rd_upper (rd_upper)
    );

    // The shared compare unit: one stored slot is tested against the request per cycle.
    assign covers = cmp_valid_reg && marks_reg[cmp_idx_reg]
                    && (rd_lower <= cmd_reg.demand_size) && (cmd_reg.demand_size <= rd_upper)
                    && (!hit_reg || (rd_upper < best_upper_reg));

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        idx_next        = idx_reg;
        cmp_valid_next  = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        hit_next        = hit_reg;
        best_next       = best_reg;
        best_upper_next = best_upper_reg;
        marks_next      = marks_reg;
        res_next        = res_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                    if (cmd.op == OP_SET)
                    begin
                        if (set_in_range)
                        begin
                            marks_next[wr_addr] = 1'b1;
                        end
                        res_next.found       = set_in_range;
                        res_next.chosen_slot = cmd.slot;
                        state_next           = ST_DONE;
                    end
                    else
                    begin
                        idx_next   = '0;
                        hit_next   = 1'b0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    idx_next       = idx_reg + CNT_W'(1);
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = idx_reg[SLOT_W-1:0];
                end
                if (covers)
                begin
                    hit_next        = 1'b1;
                    best_next       = cmp_idx_reg;
                    best_upper_next = rd_upper;
                end
                // The last compare has retired once nothing is issued or in flight.
                if (!issue && !cmp_valid_reg)
                begin
                    if (hit_reg && cmd_reg.claim)
                    begin
                        marks_next[best_reg] = 1'b0;
                    end
                    res_next.found       = hit_reg;
                    res_next.chosen_slot = hit_reg ? SLOT_FIELD_W'(best_reg) : '0;
                    state_next           = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            marks_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cmp_valid_reg <= cmp_valid_next;
            hit_reg       <= hit_next;
            marks_reg     <= marks_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        cmp_idx_reg    <= cmp_idx_next;
        best_reg       <= best_next;
        best_upper_reg <= best_upper_next;
        res_reg        <= res_next;
    end

    assign idle      = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

    a_set_marks: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> marks_reg[$past(wr_addr)])
        else $error("set transfer did not mark its slot available");

    a_marks_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_IDLE) && !start) || (state_reg == ST_DONE) |=> $stable(marks_reg))
        else $error("available marks changed outside a set or a query finish");

    a_cmp_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_valid_reg |-> (state_reg == ST_SCAN))
        else $error("compare stage active outside a scan");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= CNT_W'(SLOTS))
        else $error("scan index ran past the table");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (cmd_reg.op == OP_QUERY) && !res_reg.found |-> (res_reg.chosen_slot == '0))
        else $error("query miss reported a nonzero slot");

endmodule

>>> dv/best_fit_range_dispatcher_tb.sv
module best_fit_range_dispatcher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bfrd_pkg::*;

    localparam int NUM_SLOTS     = SLOTS_DEF;
    localparam int ITEMS_PER_PH  = 282;
    localparam int LONG_HOLD     = 300;
    localparam int DRAIN_CYCLES  = 40;
    localparam int CYCLE_LIMIT   = 400000;

    // Mirror of the slot table plus the queue of results still owed by the block.
    class dispatch_scoreboard;
        logic [BOUND_W-1:0] slot_low[NUM_SLOTS];
        logic [BOUND_W-1:0] slot_high[NUM_SLOTS];
        bit                 slot_avail[NUM_SLOTS];
        bfrd_result_t       owed_results[$];
        int                 errors;

        function new();
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                slot_low[i]   = '0;
                slot_high[i]  = '0;
                slot_avail[i] = 1'b0;
            end
            errors = 0;
        endfunction

        task report_mismatch(input string what, input int unsigned want,
                             input int unsigned got);
            $display("tb: mismatch at %0t: %s expected %0d got %0d", $realtime, what,
                     want, got);
            errors++;
        endtask

        // Works out the answer to one accepted transfer and updates the mirror.
        function void note_input(input bfrd_cmd_t c);
            bfrd_result_t       r;
            bit                 hit;
            int                 best;
            logic [BOUND_W-1:0] best_high;

            hit       = 1'b0;
            best      = 0;
            best_high = '0;
            if (c.op == OP_SET)
            begin
                if (int'(c.slot) < NUM_SLOTS)
                begin
                    slot_low[c.slot]   = c.range_low;
                    slot_high[c.slot]  = c.range_high;
                    slot_avail[c.slot] = 1'b1;
                    r.found = 1'b1;
                end
                else
                begin
                    r.found = 1'b0;
                end
                r.chosen_slot = c.slot;
            end
            else
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (slot_avail[i] && slot_low[i] <= c.demand_size &&
                        c.demand_size <= slot_high[i] && (!hit || slot_high[i] < best_high))
                    begin
                        hit       = 1'b1;
                        best      = i;
                        best_high = slot_high[i];
                    end
                end
                if (hit && c.claim)
                    slot_avail[best] = 1'b0;
                r.found       = hit;
                r.chosen_slot = hit ? SLOT_FIELD_W'(best) : '0;
            end
            owed_results.push_back(r);
        endfunction

        task check_result(input logic [M_TDATA_W-1:0] data);
            bfrd_result_t want;

            if (owed_results.size() == 0)
            begin
                report_mismatch("unexpected result, data", 0, 32'(data));
            end
            else
            begin
                want = owed_results.pop_front();
                if (data[0] !== want.found)
                    report_mismatch("found", 32'(want.found), 32'(data[0]));
                if (data[SLOT_FIELD_W:1] !== want.chosen_slot)
                    report_mismatch("chosen_slot", 32'(want.chosen_slot),
                                    32'(data[SLOT_FIELD_W:1]));
            end
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    dispatch_scoreboard sb;
    int                 send_idle_pct;
    int                 recv_stall_pct;
    int                 hold_requests;
    int                 holds_done;
    int                 cycle_count;

    best_fit_range_dispatcher u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // Receiver: random back-pressure, plus long hold-offs requested by the sender side.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (holds_done < hold_requests)
            begin
                holds_done++;
                m_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    function automatic bfrd_cmd_t make_cmd(input logic op, input int unsigned slot,
                                           input logic [31:0] lo, input logic [31:0] hi,
                                           input logic [31:0] req, input logic claim);
        bfrd_cmd_t c;

        c.op          = op;
        c.slot        = SLOT_FIELD_W'(slot);
        c.range_low   = lo;
        c.range_high  = hi;
        c.demand_size = req;
        c.claim       = claim;
        return c;
    endfunction

    // Mostly ranges and requests drawn from a narrow window so that queries often hit,
    // with wide, empty and fully random cases mixed in.
    function automatic bfrd_cmd_t random_cmd();
        bfrd_cmd_t   c;
        int unsigned k;
        logic [63:0] span;

        c = make_cmd(OP_QUERY, $urandom_range(0, 15), $urandom, $urandom, $urandom,
                     1'($urandom_range(0, 1)));
        if ($urandom_range(0, 99) < 40)
        begin
            c.op = OP_SET;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    c.range_low  = $urandom_range(0, 60);
                    c.range_high = c.range_low + $urandom_range(0, 24);
                end
                6, 7:
                begin
                    c.range_low  = $urandom;
                    c.range_high = c.range_low + ($urandom >> $urandom_range(0, 31));
                end
                8:
                begin
                    c.range_low  = $urandom_range(1, 90);
                    c.range_high = $urandom_range(0, c.range_low - 1);
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                    c.demand_size = $urandom_range(0, 90);
                6, 7, 8:
                begin
                    k = $urandom_range(0, NUM_SLOTS - 1);
                    if (sb.slot_low[k] <= sb.slot_high[k])
                    begin
                        span          = 64'(sb.slot_high[k] - sb.slot_low[k]) + 64'd1;
                        c.demand_size = sb.slot_low[k] + 32'({32'd0, $urandom} % span);
                    end
                end
                default:
                begin
                end
            endcase
        end
        return c;
    endfunction

    // Holds tvalid across back-to-back transfers; each call starts on a falling edge.
    task automatic send_item(input bfrd_cmd_t c);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, c.claim, c.demand_size, c.range_high, c.range_low, c.slot};
        s_tuser  <= c.op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_input(c);
    endtask

    initial
    begin
        bfrd_cmd_t directed[$];

        sb             = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requests  = 0;
        holds_done     = 0;
        cycle_count    = 0;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty table, full-range and top-value slots, ties on the upper bound, claims,
        // an empty range, overwriting an available slot, and ignored fields set to noise.
        directed.push_back(make_cmd(OP_QUERY, 5, $urandom, $urandom, 32'd0, 1'b1));
        directed.push_back(make_cmd(OP_SET, 0, 32'd0, 32'hFFFF_FFFF, $urandom, 1'b1));
        directed.push_back(make_cmd(OP_SET, 15, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                    32'hFFFF_FFFF, 1'b1));
        directed.push_back(make_cmd(OP_QUERY, 15, $urandom, $urandom, 32'hFFFF_FFFF, 1'b0));
        directed.push_back(make_cmd(OP_SET, 7, 32'd100, 32'd200, $urandom, 1'b0));
        directed.push_back(make_cmd(OP_SET, 3, 32'd100, 32'd200, $urandom, 1'b1));
        directed.push_back(make_cmd(OP_QUERY, 12, $urandom, $urandom, 32'd150, 1'b1));
        directed.push_back(make_cmd(OP_QUERY, 0, $urandom, $urandom, 32'd150, 1'b1));
        directed.push_back(make_cmd(OP_QUERY, 9, $urandom, $urandom, 32'd150, 1'b0));
        directed.push_back(make_cmd(OP_SET, 9, 32'd500, 32'd400, $urandom, 1'b0));
        directed.push_back(make_cmd(OP_QUERY, 9, $urandom, $urandom, 32'd450, 1'b0));
        directed.push_back(make_cmd(OP_SET, 7, 32'd10, 32'd20, $urandom, 1'b0));
        directed.push_back(make_cmd(OP_SET, 7, 32'd30, 32'd40, $urandom, 1'b1));
        directed.push_back(make_cmd(OP_QUERY, 7, $urandom, $urandom, 32'd15, 1'b0));
        directed.push_back(make_cmd(OP_QUERY, 1, $urandom, $urandom, 32'd35, 1'b1));
        directed.push_back(make_cmd(OP_QUERY, 2, $urandom, $urandom, 32'd0, 1'b1));
        directed.push_back(make_cmd(OP_QUERY, 4, $urandom, $urandom, 32'hFFFF_FFFF, 1'b1));
        directed.push_back(make_cmd(OP_QUERY, 6, $urandom, $urandom, 32'd5, 1'b1));
        directed.push_back(make_cmd(OP_SET, 9, 32'd0, 32'd0, $urandom, 1'b1));
        directed.push_back(make_cmd(OP_QUERY, 8, $urandom, $urandom, 32'd1, 1'b1));
        directed.push_back(make_cmd(OP_QUERY, 8, $urandom, $urandom, 32'd0, 1'b1));
        directed.push_back(make_cmd(OP_QUERY, 8, $urandom, $urandom, 32'd0, 1'b0));
        foreach (directed[i])
            send_item(directed[i]);

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 62;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 62;
                end
                default:
                begin
                    send_idle_pct  = 38;
                    recv_stall_pct = 38;
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PH; n++)
            begin
                // The receiver stops for a long stretch while items keep coming, so the
                // output register and the sequencer fill and s_tready drops.
                if (ph == 0 && n == 40)
                    hold_requests++;
                send_item(random_cmd());
            end
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.owed_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/bfrd_pkg.sv
hw/rtl/bfrd_bounds.sv
hw/rtl/bfrd_ctrl.sv
hw/rtl/best_fit_range_dispatcher.sv
dv/best_fit_range_dispatcher_tb.sv
